FILE: design/plsch_pkg.sv
package plsch_pkg;

	localparam int MAX_POINTS = 16;
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int NUM_W = $clog2(MAX_POINTS + 1);
	localparam int FRAC_STEPS = 16;
	localparam int QUO_STEPS = 32;
	localparam int CNT_W = $clog2(QUO_STEPS + 1);
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SPAN = 2'd2;

	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_CONST = 3'd1;
	localparam logic [2:0] REG_BEGIN = 3'd2;
	localparam logic [2:0] REG_END = 3'd3;
	localparam logic [2:0] REG_COUNT = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_ST1, S_ST2, S_FDIV, S_WALK, S_WCMP,
		S_RA, S_RB, S_MUL, S_IDIV, S_FIN, S_DONE
	} state_t;

	typedef enum logic [1:0] {RD_FIRST, RD_LAST, RD_SEG, RD_NEXT} rd_sel_t;

	typedef enum logic [1:0] {FR_ZERO, FR_ONE, FR_DIV} frac_mode_t;

	typedef struct packed {
		logic               mode;
		logic signed [31:0] const_val;
		logic [31:0]        run_begin;
		logic [31:0]        run_end;
		logic [4:0]         count;
	} cfg_t;

	typedef struct packed {
		logic    latch;
		logic    load;
		logic    finish;
		logic    do_const;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_first;
		logic    eval;
		logic    frac_step;
		logic    walk_inc;
		logic    cap_a;
		logic    cap_b;
		logic    mul;
		logic    idiv_step;
		logic    fin_write;
	} dp_cmd_t;

	typedef struct packed {
		logic mode;
		logic finished;
		logic zero_len;
		logic seg_lt;
		logic walk_gt;
		logic pb_le_pa;
	} dp_stat_t;

endpackage

FILE: design/piecewise_linear_schedule.sv
// flow, accepting edge to result beat: load, finish, constant and unused items go straight to the
// result; a finished or zero-length tick ends after reading the first and last points; an
// interpolating tick runs the 16-step fraction divider, walks the segments on the one-read table
// port, then multiplies and runs the 32-step quotient divider, which a vertical segment skips
// one item at a time, next start taken in the cycle after done; done lasts one cycle, no stall
// asynchronous active-low reset: registers with a reset to reset values, segment 0, run not finished
module piecewise_linear_schedule import plsch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic [31:0]        turn,
	input  logic [3:0]         point_index,
	input  logic [16:0]        point_position,
	input  logic signed [31:0] point_value,
	output logic               done,
	output logic signed [31:0] value,
	output logic [1:0]         status,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	cfg_t cfg;
	dp_cmd_t c;
	dp_stat_t st;

	plsch_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
	);

	plsch_ctrl u_ctrl (
		.clk, .arst_n, .start, .cmd, .st, .c, .busy, .done
	);

	plsch_dp u_dp (
		.clk, .arst_n, .cfg, .c, .turn, .point_index, .point_position, .point_value,
		.st, .value, .status
	);

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted beat did not raise busy");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("result beat longer than one cycle");
	a_zero_status: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_ZERO |-> !cfg.mode)
		else $error("zero-length status in constant mode");
`endif
endmodule

FILE: design/plsch_regs.sv
module plsch_regs import plsch_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	logic       wr;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign idx = paddr[4:2];
	assign wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.mode <= 1'b0;
			cfg.const_val <= '0;
			cfg.run_begin <= '0;
			cfg.run_end <= 32'd1;
			cfg.count <= 5'd2;
		end else if (wr) begin
			unique case (idx)
				REG_MODE: cfg.mode <= pwdata[0];
				REG_CONST: cfg.const_val <= pwdata;
				REG_BEGIN: cfg.run_begin <= pwdata;
				REG_END: cfg.run_end <= pwdata;
				REG_COUNT: cfg.count <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MODE: prdata = {31'd0, cfg.mode};
			REG_CONST: prdata = cfg.const_val;
			REG_BEGIN: prdata = cfg.run_begin;
			REG_END: prdata = cfg.run_end;
			REG_COUNT: prdata = {27'd0, cfg.count};
			default: prdata = '0;
		endcase
	end
endmodule

FILE: design/plsch_ctrl.sv
module plsch_ctrl import plsch_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] cmd,
	input  dp_stat_t   st,
	output dp_cmd_t    c,
	output logic       busy,
	output logic       done
);
	state_t state_q, nxt;
	logic [1:0] cmd_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_LOAD;
			cnt_q <= '0;
		end else begin
			state_q <= nxt;
			if (state_q == S_IDLE && start) cmd_q <= cmd;
			cnt_q <= (nxt != state_q) ? '0 : cnt_q + 1'b1;
		end
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;

	always_comb begin
		c = '0;
		nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					c.latch = 1'b1;
					nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				nxt = S_DONE;
				unique case (cmd_q)
					CMD_LOAD: c.load = 1'b1;
					CMD_FINISH: c.finish = 1'b1;
					CMD_TICK: begin
						if (st.mode) begin
							c.do_const = 1'b1;
						end else begin
							c.rd_en = 1'b1;
							c.rd_sel = RD_FIRST;
							nxt = S_ST1;
						end
					end
					default: ;
				endcase
			end
			S_ST1: begin
				c.cap_first = 1'b1;
				c.rd_en = 1'b1;
				c.rd_sel = RD_LAST;
				nxt = S_ST2;
			end
			S_ST2: begin
				c.eval = 1'b1;
				nxt = (st.finished || st.zero_len) ? S_DONE : S_FDIV;
			end
			S_FDIV: begin
				c.frac_step = 1'b1;
				if (cnt_q == CNT_W'(FRAC_STEPS - 1)) nxt = S_WALK;
			end
			S_WALK: begin
				c.rd_en = 1'b1;
				if (st.seg_lt) begin
					c.rd_sel = RD_NEXT;
					nxt = S_WCMP;
				end else begin
					c.rd_sel = RD_SEG;
					nxt = S_RA;
				end
			end
			S_WCMP: begin
				if (st.walk_gt) begin
					c.walk_inc = 1'b1;
					nxt = S_WALK;
				end else begin
					c.rd_en = 1'b1;
					c.rd_sel = RD_SEG;
					nxt = S_RA;
				end
			end
			S_RA: begin
				c.cap_a = 1'b1;
				c.rd_en = 1'b1;
				c.rd_sel = RD_NEXT;
				nxt = S_RB;
			end
			S_RB: begin
				c.cap_b = 1'b1;
				nxt = st.pb_le_pa ? S_DONE : S_MUL;
			end
			S_MUL: begin
				c.mul = 1'b1;
				nxt = S_IDIV;
			end
			S_IDIV: begin
				c.idiv_step = 1'b1;
				if (cnt_q == CNT_W'(QUO_STEPS - 1)) nxt = S_FIN;
			end
			S_FIN: begin
				c.fin_write = 1'b1;
				nxt = S_DONE;
			end
			S_DONE: nxt = S_IDLE;
			default: nxt = S_IDLE;
		endcase
	end
endmodule

FILE: design/plsch_dp.sv
module plsch_dp import plsch_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  dp_cmd_t            c,
	input  logic [31:0]        turn,
	input  logic [3:0]         point_index,
	input  logic [16:0]        point_position,
	input  logic signed [31:0] point_value,
	output dp_stat_t           st,
	output logic signed [31:0] value,
	output logic [1:0]         status
);
	logic [48:0] mem [MAX_POINTS];
	logic [48:0] rd_q;
	logic [IDX_W-1:0] rd_addr;

	logic [31:0] turn_q;
	logic [3:0]  pidx_q;
	logic [16:0] ppos_q;
	logic [31:0] pval_q;

	logic [IDX_W-1:0] seg_q;
	logic fin_q;
	logic signed [31:0] cur_q;
	logic [1:0] status_q;
	logic bad0_q;

	frac_mode_t fmode_q;
	logic [31:0] frem_q, al_q;
	logic [15:0] fq_q;
	logic [16:0] frac;

	logic [16:0] pa_q, span_q, t_q;
	logic signed [31:0] va_q;
	logic signed [32:0] diff_q;
	logic neg_q;
	logic [16:0] irem_q;
	logic [31:0] iq_q;

	logic [NUM_W-1:0] n;
	logic [IDX_W-1:0] last, nm2;
	logic [16:0] rd_pos;
	logic signed [31:0] rd_val;

	logic signed [32:0] d33, l33, dn, ln;
	logic [32:0] fsh, fsub;
	logic fge;
	logic [16:0] span, tt;
	logic signed [50:0] prod, mag;
	logic [17:0] ish, isub;
	logic ige;

	always_comb begin
		if (int'(cfg.count) < 2) n = NUM_W'(2);
		else if (int'(cfg.count) > MAX_POINTS) n = NUM_W'(MAX_POINTS);
		else n = NUM_W'(cfg.count);
	end
	assign last = IDX_W'(n - 1'b1);
	assign nm2 = IDX_W'(n - 2'd2);

	assign rd_pos = rd_q[48:32];
	assign rd_val = rd_q[31:0];

	always_comb begin
		unique case (c.rd_sel)
			RD_FIRST: rd_addr = '0;
			RD_LAST: rd_addr = last;
			RD_SEG: rd_addr = seg_q;
			RD_NEXT: rd_addr = seg_q + 1'b1;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (c.load && int'(pidx_q) < MAX_POINTS) mem[IDX_W'(pidx_q)] <= {ppos_q, pval_q};
		if (c.rd_en) rd_q <= mem[rd_addr];
	end

	always_comb begin
		unique case (fmode_q)
			FR_ZERO: frac = '0;
			FR_ONE: frac = ONE_Q16;
			default: frac = {1'b0, fq_q};
		endcase
	end

	assign d33 = $signed({1'b0, turn_q}) - $signed({1'b0, cfg.run_begin});
	assign l33 = $signed({1'b0, cfg.run_end}) - $signed({1'b0, cfg.run_begin});
	assign dn = l33[32] ? -d33 : d33;
	assign ln = l33[32] ? -l33 : l33;

	assign fsh = {frem_q, 1'b0};
	assign fge = fsh >= {1'b0, al_q};
	assign fsub = fsh - {1'b0, al_q};

	assign span = rd_pos - pa_q;
	always_comb begin
		tt = (frac > pa_q) ? frac - pa_q : '0;
		if (tt > span) tt = span;
	end

	assign prod = diff_q * $signed({1'b0, t_q});
	assign mag = prod[50] ? -prod : prod;

	assign ish = {irem_q, iq_q[31]};
	assign ige = ish >= {1'b0, span_q};
	assign isub = ish - {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= '0;
			fin_q <= 1'b0;
			cur_q <= '0;
			status_q <= STAT_OK;
		end else begin
			if (c.latch) status_q <= STAT_OK;
			if (c.load) begin
				seg_q <= '0;
				fin_q <= 1'b0;
			end
			if (c.finish) fin_q <= 1'b1;
			if (c.do_const) cur_q <= cfg.const_val;
			if (c.eval) begin
				status_q <= (bad0_q || rd_pos != ONE_Q16) ? STAT_SPAN : STAT_OK;
				if (fin_q) cur_q <= rd_val;
				else if (st.zero_len) status_q <= STAT_ZERO;
				else if (seg_q > nm2) seg_q <= nm2;
			end
			if (c.walk_inc) seg_q <= seg_q + 1'b1;
			if (c.cap_b && st.pb_le_pa) cur_q <= rd_val;
			if (c.fin_write) cur_q <= va_q + (neg_q ? -$signed(iq_q) : $signed(iq_q));
		end
	end

	always_ff @(posedge clk) begin
		if (c.latch) begin
			turn_q <= turn;
			pidx_q <= point_index;
			ppos_q <= point_position;
			pval_q <= point_value;
		end
		if (c.cap_first) bad0_q <= rd_pos != '0;
		if (c.eval) begin
			frem_q <= dn[31:0];
			al_q <= ln[31:0];
			fq_q <= '0;
			if (dn <= 0) fmode_q <= FR_ZERO;
			else if (dn >= ln) fmode_q <= FR_ONE;
			else fmode_q <= FR_DIV;
		end
		if (c.frac_step) begin
			frem_q <= fge ? fsub[31:0] : fsh[31:0];
			fq_q <= {fq_q[14:0], fge};
		end
		if (c.cap_a) begin
			pa_q <= rd_pos;
			va_q <= rd_val;
		end
		if (c.cap_b) begin
			diff_q <= 33'(rd_val) - 33'(va_q);
			span_q <= span;
			t_q <= tt;
		end
		if (c.mul) begin
			neg_q <= prod[50];
			irem_q <= mag[48:32];
			iq_q <= mag[31:0];
		end
		if (c.idiv_step) begin
			irem_q <= ige ? isub[16:0] : ish[16:0];
			iq_q <= {iq_q[30:0], ige};
		end
	end

	assign st.mode = cfg.mode;
	assign st.finished = fin_q;
	assign st.zero_len = cfg.run_end == cfg.run_begin;
	assign st.seg_lt = seg_q < nm2;
	assign st.walk_gt = frac > rd_pos;
	assign st.pb_le_pa = rd_pos <= pa_q;

	assign value = cur_q;
	assign status = status_q;
endmodule
